// ===== rtl/vmu_pkg.sv =====
// Shared types, action codes and the saturation helper of the vector math unit.
// Depends on nothing; the front, the back and the top level import it.
package vmu_pkg;

   localparam int DATA_WIDTH         = 32;
   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int MID_DEPTH          = 2;
   localparam int OUT_DEPTH          = 2;
   localparam int ROOT_STEPS         = DATA_WIDTH;

   localparam logic [3:0] ACT_ADD        = 4'd0;
   localparam logic [3:0] ACT_ADD_SCALAR = 4'd1;
   localparam logic [3:0] ACT_SUB        = 4'd2;
   localparam logic [3:0] ACT_SUB_SCALAR = 4'd3;
   localparam logic [3:0] ACT_SCALE      = 4'd4;
   localparam logic [3:0] ACT_DOT        = 4'd5;
   localparam logic [3:0] ACT_CROSS      = 4'd6;
   localparam logic [3:0] ACT_LENGTH     = 4'd7;
   localparam logic [3:0] ACT_NORMALIZE  = 4'd8;
   localparam logic [3:0] ACT_DISTANCE   = 4'd9;

   localparam logic [31:0] S32_MAX_BITS = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN_BITS = 32'h8000_0000;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_ADDSUB,
      CLS_SCALE,
      CLS_DOT,
      CLS_CROSS,
      CLS_LENGTH,
      CLS_NORM,
      CLS_DIST
   } op_class_type;

   typedef struct packed {
      logic [3:0]  action;
      logic [31:0] first_x;
      logic [31:0] first_y;
      logic [31:0] first_z;
      logic [31:0] second_x;
      logic [31:0] second_y;
      logic [31:0] second_z;
      logic [31:0] scalar_in;
   } req_type;

   typedef struct packed {
      logic [31:0] result_x;
      logic [31:0] result_y;
      logic [31:0] result_z;
      logic [31:0] result_scalar;
      logic        saturated;
      logic        zero_length;
   } rsp_type;

   // One classified request as it waits between the front and the back.
   typedef struct packed {
      op_class_type      cls;
      logic              subtract;
      logic              use_scalar;
      logic [2:0][31:0]  a;
      logic [2:0][31:0]  b;
      logic [31:0]       s;
   } work_type;

   // Partial result that travels with a request through the back pipeline.
   typedef struct packed {
      op_class_type      cls;
      logic [2:0][31:0]  vec;
      logic [31:0]       scal;
      logic              sat;
      logic              zl;
      logic [2:0]        neg;
      logic [2:0][31:0]  mag;
   } carry_type;

   // Square root iteration state.
   typedef struct packed {
      logic [63:0] n;
      logic [33:0] rem;
      logic [31:0] root;
      logic        over;
      logic        zero;
   } root_type;

   typedef struct packed {
      logic [31:0] val;
      logic        flag;
   } sat_type;

   function automatic sat_type sat32(input logic signed [71:0] v);
      sat_type r;
      r.val  = v[31:0];
      r.flag = 1'b0;
      if (v > 72'sd2147483647) begin
         r.val  = S32_MAX_BITS;
         r.flag = 1'b1;
      end else if (v < -72'sd2147483648) begin
         r.val  = S32_MIN_BITS;
         r.flag = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== rtl/vmu_fifo.sv =====
// Small flop-based queue used between front and back and at the result side.
// Depends on nothing; depth must be a power of two of at least two.
module vmu_fifo #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] rdata,
   output logic             empty
);
   localparam int AW = $clog2(Depth);

   logic [Width-1:0] mem_ff [Depth];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== rtl/vmu_front.sv =====
// Front of the vector math unit: decodes the action code of a request into an
// operation class and operand selects. Depends on vmu_pkg.
module vmu_front (
   input  vmu_pkg::req_type  req_data,
   output vmu_pkg::work_type work
);
   import vmu_pkg::*;

   always_comb begin
      work.a          = {req_data.first_z, req_data.first_y, req_data.first_x};
      work.b          = {req_data.second_z, req_data.second_y, req_data.second_x};
      work.s          = req_data.scalar_in;
      work.subtract   = (req_data.action == ACT_SUB) || (req_data.action == ACT_SUB_SCALAR);
      work.use_scalar = (req_data.action == ACT_ADD_SCALAR) ||
                        (req_data.action == ACT_SUB_SCALAR);
      unique case (req_data.action) inside
         ACT_ADD, ACT_ADD_SCALAR, ACT_SUB, ACT_SUB_SCALAR: work.cls = CLS_ADDSUB;
         ACT_SCALE:     work.cls = CLS_SCALE;
         ACT_DOT:       work.cls = CLS_DOT;
         ACT_CROSS:     work.cls = CLS_CROSS;
         ACT_LENGTH:    work.cls = CLS_LENGTH;
         ACT_NORMALIZE: work.cls = CLS_NORM;
         ACT_DISTANCE:  work.cls = CLS_DIST;
         default:       work.cls = CLS_NONE;
      endcase
   end

endmodule

// ===== rtl/vmu_back.sv =====
// Back of the vector math unit: operand select, shared multipliers, rounding,
// a pipelined square root and a pipelined divider for normalize. Depends on vmu_pkg.
module vmu_back #(
   parameter int FracBits = vmu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  vmu_pkg::work_type work,
   input  logic              work_valid,
   output logic              work_pop,
   output vmu_pkg::rsp_type  out_data,
   output logic              out_push,
   input  logic              out_full
);
   import vmu_pkg::*;

   localparam int QW = FracBits + 1;
   localparam int NW = DATA_WIDTH + FracBits + 1;
   localparam logic signed [68:0] Half = 69'sd1 <<< (FracBits - 1);

   logic advance;

   // Stage 1: operand select and add/subtract.
   carry_type          c1_ff, c1_in;
   logic               v1_ff;
   logic signed [32:0] op_a_ff [6];
   logic signed [32:0] op_a_in [6];
   logic signed [32:0] op_b_ff [6];
   logic signed [32:0] op_b_in [6];
   // Stage 2: products.
   carry_type          c2_ff;
   logic               v2_ff;
   logic signed [65:0] prod_ff [6];
   logic signed [65:0] prod_in [6];
   // Stage 3: lane sums.
   carry_type          c3_ff;
   logic               v3_ff;
   logic signed [66:0] lane_ff [3];
   logic signed [66:0] lane_in [3];
   // Stage 4: total and lane rounding.
   carry_type          c4_ff, c4_in;
   logic               v4_ff;
   logic signed [68:0] tot_ff, tot_in;
   // Square root section; index 0 is the stage that loads it.
   carry_type          sq_c_ff [ROOT_STEPS+1];
   logic               sq_v_ff [ROOT_STEPS+1];
   root_type           sq_r_ff [ROOT_STEPS+1];
   carry_type          sq_c_in [ROOT_STEPS+1];
   root_type           sq_r_in [ROOT_STEPS+1];
   // Divider section; index 0 is the root rounding stage.
   carry_type          dv_c_ff [QW+1];
   logic               dv_v_ff [QW+1];
   logic [32:0]        dv_len_ff [QW+1];
   logic [QW-1:0]      dv_num_ff [QW+1][3];
   logic [32:0]        dv_rem_ff [QW+1][3];
   logic [QW-1:0]      dv_q_ff [QW+1][3];
   carry_type          dv_c_in [QW+1];
   logic [32:0]        dv_len_in [QW+1];
   logic [QW-1:0]      dv_num_in [QW+1][3];
   logic [32:0]        dv_rem_in [QW+1][3];
   logic [QW-1:0]      dv_q_in [QW+1][3];

   assign advance  = !(dv_v_ff[QW] && out_full);
   assign work_pop = work_valid && advance;
   assign out_push = dv_v_ff[QW] && !out_full;

   always_comb begin
      logic signed [32:0] ae [3];
      logic signed [32:0] be [3];
      logic signed [32:0] de [3];
      logic signed [32:0] se, ov, rv;
      sat_type            st;
      c1_in     = '0;
      c1_in.cls = work.cls;
      se        = 33'($signed(work.s));
      for (int i = 0; i < 3; i++) begin
         ae[i] = 33'($signed(work.a[i]));
         be[i] = 33'($signed(work.b[i]));
         de[i] = ae[i] - be[i];
         ov    = work.use_scalar ? se : be[i];
         rv    = work.subtract ? ae[i] - ov : ae[i] + ov;
         st    = sat32(72'(rv));
         if (work.cls == CLS_ADDSUB) begin
            c1_in.vec[i] = st.val;
            c1_in.sat    = c1_in.sat | st.flag;
         end
         c1_in.neg[i] = work.a[i][31];
         c1_in.mag[i] = work.a[i][31] ? 32'(-ae[i]) : work.a[i];
      end
      for (int k = 0; k < 6; k++) begin
         op_a_in[k] = '0;
         op_b_in[k] = '0;
      end
      unique case (work.cls)
         CLS_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               op_a_in[i] = ae[i];
               op_b_in[i] = se;
            end
         end
         CLS_DOT: begin
            for (int i = 0; i < 3; i++) begin
               op_a_in[i] = ae[i];
               op_b_in[i] = be[i];
            end
         end
         CLS_CROSS: begin
            op_a_in[0] = ae[1]; op_b_in[0] = be[2];
            op_a_in[3] = ae[2]; op_b_in[3] = -be[1];
            op_a_in[1] = ae[2]; op_b_in[1] = be[0];
            op_a_in[4] = ae[0]; op_b_in[4] = -be[2];
            op_a_in[2] = ae[0]; op_b_in[2] = be[1];
            op_a_in[5] = ae[1]; op_b_in[5] = -be[0];
         end
         CLS_LENGTH, CLS_NORM: begin
            for (int i = 0; i < 3; i++) begin
               op_a_in[i] = ae[i];
               op_b_in[i] = ae[i];
            end
         end
         CLS_DIST: begin
            for (int i = 0; i < 3; i++) begin
               op_a_in[i] = de[i];
               op_b_in[i] = de[i];
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         prod_in[k] = op_a_ff[k] * op_b_ff[k];
      end
      for (int i = 0; i < 3; i++) begin
         lane_in[i] = 67'(prod_ff[i]) + 67'(prod_ff[i+3]);
      end
   end

   always_comb begin
      sat_type st;
      c4_in  = c3_ff;
      tot_in = 69'(lane_ff[0]) + 69'(lane_ff[1]) + 69'(lane_ff[2]);
      for (int i = 0; i < 3; i++) begin
         st = sat32(72'((69'(lane_ff[i]) + Half) >>> FracBits));
         if ((c3_ff.cls == CLS_SCALE) || (c3_ff.cls == CLS_CROSS)) begin
            c4_in.vec[i] = st.val;
            c4_in.sat    = c4_in.sat | st.flag;
         end
      end
   end

   // Stage 5 rounds the dot product and loads the square root.
   always_comb begin
      sat_type st;
      sq_c_in[0] = c4_ff;
      st         = sat32(72'((tot_ff + Half) >>> FracBits));
      if (c4_ff.cls == CLS_DOT) begin
         sq_c_in[0].scal = st.val;
         sq_c_in[0].sat  = st.flag;
      end
      sq_r_in[0].n    = tot_ff[63:0];
      sq_r_in[0].rem  = '0;
      sq_r_in[0].root = '0;
      sq_r_in[0].over = |tot_ff[68:64];
      sq_r_in[0].zero = (tot_ff == '0);
   end

   // One result bit of the square root per stage.
   for (genvar g = 1; g <= ROOT_STEPS; g++) begin : g_root
      always_comb begin
         logic [35:0] cur, trial;
         root_type    r;
         r          = sq_r_ff[g-1];
         cur        = {r.rem, r.n[63:62]};
         trial      = {2'b00, r.root, 2'b01};
         sq_c_in[g] = sq_c_ff[g-1];
         sq_r_in[g] = r;
         sq_r_in[g].n = {r.n[61:0], 2'b00};
         if (cur >= trial) begin
            sq_r_in[g].rem  = 34'(cur - trial);
            sq_r_in[g].root = {r.root[30:0], 1'b1};
         end else begin
            sq_r_in[g].rem  = cur[33:0];
            sq_r_in[g].root = {r.root[30:0], 1'b0};
         end
      end
   end

   // Root rounding, length and distance results, divider load.
   always_comb begin
      root_type    r;
      logic        up;
      logic [32:0] rnd;
      logic [NW-1:0] numw;
      r          = sq_r_ff[ROOT_STEPS];
      dv_c_in[0] = sq_c_ff[ROOT_STEPS];
      up         = r.rem > 34'(r.root);
      rnd        = 33'(r.root) + 33'(up);
      if ((dv_c_in[0].cls == CLS_LENGTH) || (dv_c_in[0].cls == CLS_DIST)) begin
         if (r.over || (rnd > 33'(S32_MAX_BITS))) begin
            dv_c_in[0].scal = S32_MAX_BITS;
            dv_c_in[0].sat  = 1'b1;
         end else begin
            dv_c_in[0].scal = rnd[31:0];
         end
      end
      if ((dv_c_in[0].cls == CLS_NORM) && r.zero) begin
         dv_c_in[0].zl = 1'b1;
      end
      dv_len_in[0] = rnd;
      for (int i = 0; i < 3; i++) begin
         numw = (NW'(dv_c_in[0].mag[i]) << FracBits) + NW'(rnd >> 1);
         dv_num_in[0][i] = numw[QW-1:0];
         dv_rem_in[0][i] = 33'(numw[NW-1:QW]);
         dv_q_in[0][i]   = '0;
      end
   end

   // One quotient bit per stage for all three components.
   for (genvar g = 1; g <= QW; g++) begin : g_div
      always_comb begin
         logic [33:0] cur, dvs;
         logic        qb;
         dv_c_in[g]   = dv_c_ff[g-1];
         dv_len_in[g] = dv_len_ff[g-1];
         dvs          = {1'b0, dv_len_ff[g-1]};
         for (int i = 0; i < 3; i++) begin
            cur = {dv_rem_ff[g-1][i], dv_num_ff[g-1][i][QW-1]};
            qb  = (cur >= dvs);
            dv_rem_in[g][i] = qb ? 33'(cur - dvs) : cur[32:0];
            dv_num_in[g][i] = {dv_num_ff[g-1][i][QW-2:0], 1'b0};
            dv_q_in[g][i]   = {dv_q_ff[g-1][i][QW-2:0], qb};
         end
      end
   end

   always_comb begin
      carry_type   c;
      logic [31:0] q32;
      logic [2:0][31:0] vec;
      c   = dv_c_ff[QW];
      vec = c.vec;
      for (int i = 0; i < 3; i++) begin
         q32 = 32'(dv_q_ff[QW][i]);
         if ((c.cls == CLS_NORM) && !c.zl) begin
            vec[i] = c.neg[i] ? 32'(-q32) : q32;
         end
      end
      out_data.result_x      = vec[0];
      out_data.result_y      = vec[1];
      out_data.result_z      = vec[2];
      out_data.result_scalar = c.scal;
      out_data.saturated     = c.sat;
      out_data.zero_length   = c.zl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= work_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff   <= c1_in;
         op_a_ff <= op_a_in;
         op_b_ff <= op_b_in;
         c2_ff   <= c1_ff;
         prod_ff <= prod_in;
         c3_ff   <= c2_ff;
         lane_ff <= lane_in;
         c4_ff   <= c4_in;
         tot_ff  <= tot_in;
      end
   end

   for (genvar g = 0; g <= ROOT_STEPS; g++) begin : g_root_regs
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[g] <= 1'b0;
         end else if (advance) begin
            sq_v_ff[g] <= (g == 0) ? v4_ff : sq_v_ff[(g == 0) ? 0 : g-1];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            sq_c_ff[g] <= sq_c_in[g];
            sq_r_ff[g] <= sq_r_in[g];
         end
      end
   end

   for (genvar g = 0; g <= QW; g++) begin : g_div_regs
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[g] <= 1'b0;
         end else if (advance) begin
            dv_v_ff[g] <= (g == 0) ? sq_v_ff[ROOT_STEPS] : dv_v_ff[(g == 0) ? 0 : g-1];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            dv_c_ff[g]   <= dv_c_in[g];
            dv_len_ff[g] <= dv_len_in[g];
            dv_num_ff[g] <= dv_num_in[g];
            dv_rem_ff[g] <= dv_rem_in[g];
            dv_q_ff[g]   <= dv_q_in[g];
         end
      end
   end

   // A stalled last stage freezes its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      dv_v_ff[QW] && out_full |=> dv_v_ff[QW] && $stable(dv_c_ff[QW]))
      else $error("last stage changed while stalled");

   // Zero-length results only come from normalize and carry a zero vector.
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      dv_v_ff[QW] && dv_c_ff[QW].zl |-> dv_c_ff[QW].cls == CLS_NORM && out_data.result_x == '0
      && out_data.result_y == '0 && out_data.result_z == '0)
      else $error("zero_length without a zero normalize result");

   // The request queue is popped only while the back moves.
   a_pop: assert property (@(posedge clock) disable iff (reset)
      work_pop |-> advance && work_valid)
      else $error("request popped during a stall");

endmodule

// ===== rtl/vec3_math_unit.sv =====
// Top level of the three-component fixed-point vector unit.
// Depends on vmu_pkg, vmu_front, vmu_fifo and vmu_back.
//
//   Channel    Handshake           Payload
//   request    push / full         req_data  (vmu_pkg::req_type)
//   response   pop / empty         rsp_data  (vmu_pkg::rsp_type)
//
// The unit takes one request per cycle while its request queue has room and
// returns one response per request in order. A request passes, in order,
// through operand select, multiply and rounding (the first of these loads
// straight from the request queue), the square root, root rounding, the
// normalize divider and the response queue register.
// Reset is synchronous and empties both queues and the pipeline. When the
// response queue is full and a result waits to enter it, the whole back
// pipeline holds; the request queue keeps taking requests until it fills.
module vec3_math_unit #(
   parameter int FracBits = vmu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  vmu_pkg::req_type req_data,
   input  logic             pop,
   output logic             empty,
   output vmu_pkg::rsp_type rsp_data
);
   import vmu_pkg::*;

   work_type work_front;
   work_type work_back;
   logic     mid_empty;
   logic     mid_pop;
   rsp_type  back_data;
   logic     back_push;
   logic     out_full;

   // The front only classifies; the decoded request is stored in the queue.
   vmu_front u_front (
      .req_data (req_data),
      .work     (work_front)
   );

   // Short queue that lets the front keep accepting while the back stalls.
   vmu_fifo #(
      .Width ($bits(work_type)),
      .Depth (MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (work_front),
      .full  (full),
      .pop   (mid_pop),
      .rdata (work_back),
      .empty (mid_empty)
   );

   // The back carries out every action over a fixed-length pipeline so that
   // responses leave in request order.
   vmu_back #(
      .FracBits (FracBits)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .work       (work_back),
      .work_valid (!mid_empty),
      .work_pop   (mid_pop),
      .out_data   (back_data),
      .out_push   (back_push),
      .out_full   (out_full)
   );

   // Response queue; it registers the result and parts the two sides.
   vmu_fifo #(
      .Width ($bits(rsp_type)),
      .Depth (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (back_push),
      .wdata (back_data),
      .full  (out_full),
      .pop   (pop),
      .rdata (rsp_data),
      .empty (empty)
   );

   // A response never reports both a clamp and a zero-length vector.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_data.saturated && rsp_data.zero_length))
      else $error("saturated and zero_length both set");

   // After reset nothing is waiting on the response side.
   a_reset: assert property (@(posedge clock)
      reset |=> empty)
      else $error("response waiting after reset");

   // A zero-length normalize response carries a zero scalar.
   a_scalar: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.zero_length |-> rsp_data.result_scalar == '0)
      else $error("normalize response with a scalar value");

endmodule
